>>> rtl/core/prel_pkg.sv
// ============================================================================
// Pitch-rate envelope limiter package
// Shared widths, register indexes, arithmetic constants and pipeline layout.
// ============================================================================
package prel_pkg;

    // Field widths
    localparam int SPD_W      = 14;
    localparam int ANG_W      = 16;
    localparam int LOAD_W     = 13;
    localparam int GAIN_W     = 16;
    localparam int CAP_W      = 15;
    localparam int OUT_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CAP      = 3'd5;

    // Speed conversion: 1/16 kt to ft/s in Q8, rounded, floored at 50 ft/s
    localparam int                 CONV_W       = 21;
    localparam logic [CONV_W-1:0]  SPEED_CONV   = 21'd1769797;
    localparam int                 VPROD_W      = 35;
    localparam int                 V8_W         = 19;
    localparam logic [V8_W-1:0]    SPEED_MIN_Q8 = 19'd12800;

    // Gravity in Q16 and the one-g offset
    localparam int                 GRAV_W       = 22;
    localparam logic [GRAV_W-1:0]  GRAV_Q16     = 22'd2108555;
    localparam int                 NOFS_W       = LOAD_W + 1;
    localparam logic signed [NOFS_W-1:0] ONE_G  = 14'sd256;
    localparam int                 NMAG_W       = LOAD_W;
    localparam int                 PRODN_W      = NMAG_W + GRAV_W;

    // Load-bound divider
    localparam int                 DIV_BITS     = 16;
    localparam int                 DIV_NUM_W    = 34;
    localparam int                 DEN_W        = V8_W + 4;

    // Angle bound
    localparam int                 DIFF_W       = ANG_W + 1;
    localparam int                 PRODA_W      = 2 * DIFF_W;
    localparam int                 QA_W         = PRODA_W - 8;

    // Pipeline layout: three prep stages, one stage per quotient bit, output
    localparam int                 STG_DIV0     = 3;
    localparam int                 STG_LAST     = STG_DIV0 + DIV_BITS;
    localparam int                 NUM_STG      = STG_LAST + 1;

    // Saturate a wide signed rate to the output width
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [QA_W-1:0] v);
        logic all_one;
        logic any_one;
        logic [OUT_W-1:0] res;
        all_one = &v[QA_W-1:OUT_W-1];
        any_one = |v[QA_W-1:OUT_W-1];
        if (all_one || !any_one) begin
            res = v[OUT_W-1:0];
        end else if (v[QA_W-1]) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> rtl/core/prel_div.sv
// ============================================================================
// Pipelined restoring divider
// Unsigned quotient of a rounded numerator by the scaled speed, one quotient
// bit per register stage, each stage held by its own advance enable.
// ============================================================================
module prel_div (
    input  logic                           i_clk,
    input  logic [prel_pkg::DIV_BITS-1:0]  i_adv,
    input  logic [prel_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [prel_pkg::DEN_W-1:0]     i_den,
    output logic [prel_pkg::DIV_BITS-1:0]  o_quo
);
    import prel_pkg::*;

    localparam int CMP_W = DEN_W + DIV_BITS - 1;

    logic [DIV_NUM_W-1:0] r_rem [0:DIV_BITS-2];
    logic [DEN_W-1:0]     r_den [0:DIV_BITS-2];
    logic [DIV_BITS-1:0]  r_quo [0:DIV_BITS-1];

    logic [DIV_NUM_W-1:0] w_rem_in [0:DIV_BITS-1];
    logic [DEN_W-1:0]     w_den_in [0:DIV_BITS-1];
    logic [DIV_BITS-1:0]  w_quo_in [0:DIV_BITS-1];

    assign w_rem_in[0] = i_num;
    assign w_den_in[0] = i_den;
    assign w_quo_in[0] = '0;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
        localparam int SH = DIV_BITS - 1 - k;

        logic [CMP_W-1:0] n_dsh;
        logic [CMP_W-1:0] n_rem_ext;
        logic             n_ge;

        // Compare the remainder against the divisor shifted to this bit
        assign n_dsh     = CMP_W'(w_den_in[k]) << SH;
        assign n_rem_ext = CMP_W'(w_rem_in[k]);
        assign n_ge      = (n_rem_ext >= n_dsh);

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_quo[k] <= {w_quo_in[k][DIV_BITS-2:0], n_ge};
            end
        end

        if (k < DIV_BITS - 1) begin : g_carry
            logic [CMP_W-1:0] n_diff;

            assign n_diff = n_rem_ext - n_dsh;

            // Subtract when it fits, advance remainder and divisor
            always_ff @(posedge i_clk) begin
                if (i_adv[k]) begin
                    r_rem[k] <= n_ge ? n_diff[DIV_NUM_W-1:0] : w_rem_in[k];
                    r_den[k] <= w_den_in[k];
                end
            end

            assign w_rem_in[k+1] = r_rem[k];
            assign w_den_in[k+1] = r_den[k];
            assign w_quo_in[k+1] = r_quo[k];
        end
    end

    assign o_quo = r_quo[DIV_BITS-1];

endmodule

>>> rtl/core/pitch_rate_envelope_limiter.sv
// ============================================================================
// Pitch-rate envelope limiter
// Forms upper and lower pitch-rate limits from airspeed, angle of attack,
// load-factor command and angle window, bounded by the hard limits.
// ============================================================================
//
//  channel   valid / ready               payload
//  -------   -------------------------   ----------------------------------
//  input     i_in_valid / o_in_ready     airspeed, angle, load, angle window
//  output    o_out_valid / i_out_ready   upper and lower pitch-rate limits
//  config    i_cfg_valid / o_cfg_ready   register index, write data
//
//  One request enters per cycle when not stalled; the stages are three prep
//  stages, sixteen quotient stages of the load-bound divider (one bit each)
//  and the output register. Each stage holds only while it is full and the
//  stage after it holds, so bubbles close up under an output stall and
//  nothing is dropped or repeated. Reset clears the valid bits and loads
//  the register defaults; configuration writes are taken every cycle.
//
module pitch_rate_envelope_limiter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [prel_pkg::SPD_W-1:0]             i_airspeed,
    input  logic signed [prel_pkg::ANG_W-1:0]      i_angle_of_attack,
    input  logic signed [prel_pkg::LOAD_W-1:0]     i_load_request,
    input  logic signed [prel_pkg::ANG_W-1:0]      i_alpha_upper_request,
    input  logic signed [prel_pkg::ANG_W-1:0]      i_alpha_lower_request,

    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [prel_pkg::OUT_W-1:0]      o_pitch_rate_upper,
    output logic signed [prel_pkg::OUT_W-1:0]      o_pitch_rate_lower,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [prel_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [prel_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import prel_pkg::*;

    localparam logic [DEN_W-1:0]    DEN_MIN  = {SPEED_MIN_Q8, 4'b0000};
    localparam logic [DIV_BITS-1:0] QUO_MAX  = 16'd44807;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0]  r_alpha_floor;
    logic signed [ANG_W-1:0]  r_alpha_ceiling;
    logic signed [LOAD_W-1:0] r_load_floor;
    logic signed [LOAD_W-1:0] r_load_ceiling;
    logic [GAIN_W-1:0]        r_alpha_gain;
    logic [CAP_W-1:0]         r_rate_cap;

    assign o_cfg_ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_floor   <= -16'sd819;
            r_alpha_ceiling <= 16'sd1434;
            r_load_floor    <= -13'sd256;
            r_load_ceiling  <= 13'sd640;
            r_alpha_gain    <= 16'd512;
            r_rate_cap      <= 15'd2048;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ALPHA_FLOOR:   r_alpha_floor   <= i_cfg_data;
                CFG_ALPHA_CEILING: r_alpha_ceiling <= i_cfg_data;
                CFG_LOAD_FLOOR:    r_load_floor    <= i_cfg_data[LOAD_W-1:0];
                CFG_LOAD_CEILING:  r_load_ceiling  <= i_cfg_data[LOAD_W-1:0];
                CFG_ALPHA_GAIN:    r_alpha_gain    <= i_cfg_data;
                CFG_RATE_CAP:      r_rate_cap      <= i_cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_adv;

    // A stage advances when empty or when the next one advances
    always_comb begin
        w_adv[STG_LAST] = !r_vld[STG_LAST] || i_out_ready;
        for (int k = STG_LAST - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[STG_LAST];

    // ------------------------------------------------------------------
    // Stage 0: speed product, load clamp, angle window clamp
    // ------------------------------------------------------------------
    logic [VPROD_W-1:0]       n_vprod;
    logic signed [LOAD_W-1:0] n_nlo;
    logic signed [LOAD_W-1:0] n_nup;
    logic signed [NOFS_W-1:0] n_nm;
    logic signed [NOFS_W-1:0] n_neg_nm;
    logic signed [NOFS_W-1:0] n_fm;
    logic signed [NOFS_W-1:0] n_neg_fm;
    logic signed [ANG_W-1:0]  n_ahi;
    logic signed [ANG_W-1:0]  n_alo;

    always_comb begin
        n_vprod  = VPROD_W'(i_airspeed) * VPROD_W'(SPEED_CONV);
        n_nlo    = (i_load_request < r_load_floor) ? r_load_floor : i_load_request;
        n_nup    = (n_nlo > r_load_ceiling) ? r_load_ceiling : n_nlo;
        n_nm     = {n_nup[LOAD_W-1], n_nup} - ONE_G;
        n_neg_nm = -n_nm;
        n_fm     = {r_load_floor[LOAD_W-1], r_load_floor} - ONE_G;
        n_neg_fm = -n_fm;
        n_ahi    = (i_alpha_upper_request > r_alpha_ceiling) ? r_alpha_ceiling
                                                             : i_alpha_upper_request;
        n_alo    = (i_alpha_lower_request < r_alpha_floor) ? r_alpha_floor
                                                           : i_alpha_lower_request;
    end

    logic [VPROD_W-1:0]      r_vprod;
    logic [NMAG_W-1:0]       r_nmag_up;
    logic [NMAG_W-1:0]       r_nmag_lo;
    logic signed [ANG_W-1:0] r_ahi;
    logic signed [ANG_W-1:0] r_alo;
    logic signed [ANG_W-1:0] r_aoa;
    logic                    r_sgn_up [0:STG_LAST-1];
    logic                    r_sgn_lo [0:STG_LAST-1];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_vprod     <= n_vprod;
            r_nmag_up   <= n_nm[NOFS_W-1] ? n_neg_nm[NMAG_W-1:0] : n_nm[NMAG_W-1:0];
            r_nmag_lo   <= n_fm[NOFS_W-1] ? n_neg_fm[NMAG_W-1:0] : n_fm[NMAG_W-1:0];
            r_ahi       <= n_ahi;
            r_alo       <= n_alo;
            r_aoa       <= i_angle_of_attack;
        end
    end

    // Capture the load-bound signs and carry them down to the output stage
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_sgn_up[0] <= n_nm[NOFS_W-1];
            r_sgn_lo[0] <= n_fm[NOFS_W-1];
        end
        for (int k = 1; k < STG_LAST; k++) begin
            if (w_adv[k]) begin
                r_sgn_up[k] <= r_sgn_up[k-1];
                r_sgn_lo[k] <= r_sgn_lo[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: round and floor speed, gravity products, angle errors
    // ------------------------------------------------------------------
    logic [VPROD_W-1:0]       n_vrnd;
    logic [V8_W-1:0]          n_v8raw;
    logic [V8_W-1:0]          n_v8;
    logic signed [DIFF_W-1:0] n_dhi;
    logic signed [DIFF_W-1:0] n_dlo;

    always_comb begin
        n_vrnd  = r_vprod + VPROD_W'(32768);
        n_v8raw = n_vrnd[VPROD_W-1:16];
        n_v8    = (n_v8raw < SPEED_MIN_Q8) ? SPEED_MIN_Q8 : n_v8raw;
        n_dhi   = {r_ahi[ANG_W-1], r_ahi} - {r_aoa[ANG_W-1], r_aoa};
        n_dlo   = {r_alo[ANG_W-1], r_alo} - {r_aoa[ANG_W-1], r_aoa};
    end

    logic [V8_W-1:0]          r_v8;
    logic [PRODN_W-1:0]       r_pn_up;
    logic [PRODN_W-1:0]       r_pn_lo;
    logic signed [DIFF_W-1:0] r_dhi;
    logic signed [DIFF_W-1:0] r_dlo;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_v8    <= n_v8;
            r_pn_up <= PRODN_W'(r_nmag_up) * PRODN_W'(GRAV_Q16);
            r_pn_lo <= PRODN_W'(r_nmag_lo) * PRODN_W'(GRAV_Q16);
            r_dhi   <= n_dhi;
            r_dlo   <= n_dlo;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rounded numerators, divisor, angle-gain products
    // ------------------------------------------------------------------
    logic [PRODN_W-1:0]        n_sum_up;
    logic [PRODN_W-1:0]        n_sum_lo;
    logic signed [PRODA_W-1:0] n_phi;
    logic signed [PRODA_W-1:0] n_plo;

    always_comb begin
        n_sum_up = r_pn_up + PRODN_W'({r_v8, 3'b000});
        n_sum_lo = r_pn_lo + PRODN_W'({r_v8, 3'b000});
        n_phi    = $signed({1'b0, r_alpha_gain}) * r_dhi;
        n_plo    = $signed({1'b0, r_alpha_gain}) * r_dlo;
    end

    logic [DIV_NUM_W-1:0]      r_num_up;
    logic [DIV_NUM_W-1:0]      r_num_lo;
    logic [DEN_W-1:0]          r_den;
    logic signed [PRODA_W-1:0] r_phi;
    logic signed [PRODA_W-1:0] r_plo;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_num_up <= n_sum_up[DIV_NUM_W-1:0];
            r_num_lo <= n_sum_lo[DIV_NUM_W-1:0];
            r_den    <= {r_v8, 4'b0000};
            r_phi    <= n_phi;
            r_plo    <= n_plo;
        end
    end

    // ------------------------------------------------------------------
    // Load-bound dividers, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DIV_BITS-1:0] w_quo_up;
    logic [DIV_BITS-1:0] w_quo_lo;

    prel_div u_div_up (
        .i_clk (i_clk),
        .i_adv (w_adv[STG_DIV0 +: DIV_BITS]),
        .i_num (r_num_up),
        .i_den (r_den),
        .o_quo (w_quo_up)
    );

    prel_div u_div_lo (
        .i_clk (i_clk),
        .i_adv (w_adv[STG_DIV0 +: DIV_BITS]),
        .i_num (r_num_lo),
        .i_den (r_den),
        .o_quo (w_quo_lo)
    );

    // ------------------------------------------------------------------
    // Stage 3: round angle bounds half away from zero (divide by 256)
    // ------------------------------------------------------------------
    logic signed [PRODA_W-1:0] n_rhi;
    logic signed [PRODA_W-1:0] n_rlo;

    always_comb begin
        n_rhi = r_phi + (r_phi[PRODA_W-1] ? PRODA_W'(127) : PRODA_W'(128));
        n_rlo = r_plo + (r_plo[PRODA_W-1] ? PRODA_W'(127) : PRODA_W'(128));
    end

    logic signed [QA_W-1:0] r_qa_hi;
    logic signed [QA_W-1:0] r_qa_lo;

    always_ff @(posedge i_clk) begin
        if (w_adv[STG_DIV0]) begin
            r_qa_hi <= n_rhi[PRODA_W-1:8];
            r_qa_lo <= n_rlo[PRODA_W-1:8];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: cap angle bounds by the rate limit and saturate
    // ------------------------------------------------------------------
    logic signed [QA_W-1:0] n_cap;
    logic signed [QA_W-1:0] n_ncap;
    logic signed [QA_W-1:0] n_chi;
    logic signed [QA_W-1:0] n_clo;

    always_comb begin
        n_cap  = $signed(QA_W'(r_rate_cap));
        n_ncap = -n_cap;
        n_chi  = (r_qa_hi < n_cap) ? r_qa_hi : n_cap;
        n_clo  = (r_qa_lo > n_ncap) ? r_qa_lo : n_ncap;
    end

    logic signed [OUT_W-1:0] r_lim_hi [STG_DIV0+1:STG_LAST-1];
    logic signed [OUT_W-1:0] r_lim_lo [STG_DIV0+1:STG_LAST-1];

    always_ff @(posedge i_clk) begin
        if (w_adv[STG_DIV0+1]) begin
            r_lim_hi[STG_DIV0+1] <= sat_out(n_chi);
            r_lim_lo[STG_DIV0+1] <= sat_out(n_clo);
        end
        for (int k = STG_DIV0 + 2; k < STG_LAST; k++) begin
            if (w_adv[k]) begin
                r_lim_hi[k] <= r_lim_hi[k-1];
                r_lim_lo[k] <= r_lim_lo[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign the load bounds, combine, register
    // ------------------------------------------------------------------
    logic signed [DIV_BITS:0] n_qp_up;
    logic signed [DIV_BITS:0] n_qp_lo;
    logic signed [DIV_BITS:0] n_qn_up;
    logic signed [DIV_BITS:0] n_qn_lo;
    logic signed [OUT_W-1:0]  n_sn_up;
    logic signed [OUT_W-1:0]  n_sn_lo;
    logic signed [OUT_W-1:0]  n_out_up;
    logic signed [OUT_W-1:0]  n_out_lo;

    always_comb begin
        n_qp_up  = $signed({1'b0, w_quo_up});
        n_qp_lo  = $signed({1'b0, w_quo_lo});
        n_qn_up  = r_sgn_up[STG_LAST-1] ? -n_qp_up : n_qp_up;
        n_qn_lo  = r_sgn_lo[STG_LAST-1] ? -n_qp_lo : n_qp_lo;
        n_sn_up  = sat_out(QA_W'(n_qn_up));
        n_sn_lo  = sat_out(QA_W'(n_qn_lo));
        n_out_up = (n_sn_up < r_lim_hi[STG_LAST-1]) ? n_sn_up : r_lim_hi[STG_LAST-1];
        n_out_lo = (n_sn_lo > r_lim_lo[STG_LAST-1]) ? n_sn_lo : r_lim_lo[STG_LAST-1];
    end

    logic signed [OUT_W-1:0] r_out_up;
    logic signed [OUT_W-1:0] r_out_lo;

    always_ff @(posedge i_clk) begin
        if (w_adv[STG_LAST]) begin
            r_out_up <= n_out_up;
            r_out_lo <= n_out_lo;
        end
    end

    assign o_pitch_rate_upper = r_out_up;
    assign o_pitch_rate_lower = r_out_lo;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_den_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r_den >= DEN_MIN)
        else $error("divisor below the minimum speed");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STG_LAST-1] |-> (w_quo_up <= QUO_MAX) && (w_quo_lo <= QUO_MAX))
        else $error("load-bound quotient out of range");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[STG_LAST-1]))
        else $error("result appeared without a request behind it");

endmodule
